### hdl/qvc_pkg.sv
// Shared types, constants and functions of the dual quadrature velocity counter.
package qvc_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int OUT_COUNT_WIDTH = 16;
    localparam int SCALE_WIDTH     = 24;
    localparam int VEL_WIDTH       = 40;
    localparam int PADDR_WIDTH     = 3;
    localparam int TDATA_IN_WIDTH  = 8;
    localparam int TDATA_OUT_WIDTH = 2 * OUT_COUNT_WIDTH + 3 * VEL_WIDTH;
    localparam int SAT_CMP_WIDTH   = 33;

    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 24'd65536;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic REG_DISTANCE_SCALE = 1'b0;

    typedef struct packed {
        logic left_b;
        logic left_a;
        logic right_b;
        logic right_a;
    } qvc_pins_t;

    typedef struct packed {
        logic                               valid;
        logic signed [OUT_COUNT_WIDTH-1:0]  right_count;
        logic signed [OUT_COUNT_WIDTH-1:0]  left_count;
        logic                               invalid_seen;
    } qvc_latch_t;

    function automatic logic signed [OUT_COUNT_WIDTH-1:0] sat_count(
        input logic signed [COUNT_WIDTH-1:0] v
    );
        logic signed [SAT_CMP_WIDTH-1:0] wide;
        logic signed [SAT_CMP_WIDTH-1:0] hi;
        logic signed [SAT_CMP_WIDTH-1:0] lo;
        wide = SAT_CMP_WIDTH'(v);
        hi   = SAT_CMP_WIDTH'(signed'({1'b0, {(OUT_COUNT_WIDTH-1){1'b1}}}));
        lo   = SAT_CMP_WIDTH'(signed'({1'b1, {(OUT_COUNT_WIDTH-1){1'b0}}}));
        if (wide > hi)
            sat_count = hi[OUT_COUNT_WIDTH-1:0];
        else if (wide < lo)
            sat_count = lo[OUT_COUNT_WIDTH-1:0];
        else
            sat_count = wide[OUT_COUNT_WIDTH-1:0];
    endfunction

endpackage

### hdl/qvc_decoder.sv
// Quadrature decoding of both encoders, saturating accumulators and count latch.
module qvc_decoder
    import qvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        advance,
    input  logic        cmd,
    input  qvc_pins_t   pins,
    output qvc_latch_t  latch
);

    localparam logic signed [COUNT_WIDTH-1:0] AccMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] AccMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic up;
        logic down;
        logic invalid;
    } qvc_step_t;

    function automatic qvc_step_t decode(
        input logic pa,
        input logic pb,
        input logic a,
        input logic b
    );
        qvc_step_t s;
        logic ea;
        logic eb;
        ea = pa ^ a;
        eb = pb ^ b;
        s.invalid = ea & eb;
        s.up      = (ea & ~eb & (a == b)) | (eb & ~ea & (a != b));
        s.down    = (ea & ~eb & (a != b)) | (eb & ~ea & (a == b));
        return s;
    endfunction

    function automatic logic signed [COUNT_WIDTH-1:0] step_acc(
        input logic signed [COUNT_WIDTH-1:0] acc,
        input qvc_step_t s
    );
        if (s.up && acc != AccMax)
            step_acc = acc + COUNT_WIDTH'(1);
        else if (s.down && acc != AccMin)
            step_acc = acc - COUNT_WIDTH'(1);
        else
            step_acc = acc;
    endfunction

    qvc_pins_t                      prev_pins_reg;
    logic                           pins_known_reg;
    logic signed [COUNT_WIDTH-1:0]  right_acc_reg;
    logic signed [COUNT_WIDTH-1:0]  left_acc_reg;
    logic                           invalid_reg;
    qvc_latch_t                     latch_reg;

    qvc_pins_t                      prev_pins_next;
    logic                           pins_known_next;
    logic signed [COUNT_WIDTH-1:0]  right_acc_next;
    logic signed [COUNT_WIDTH-1:0]  left_acc_next;
    logic                           invalid_next;
    qvc_latch_t                     latch_next;
    qvc_step_t                      right_step;
    qvc_step_t                      left_step;

    always_comb
    begin
        right_step = decode(prev_pins_reg.right_a, prev_pins_reg.right_b,
                            pins.right_a, pins.right_b);
        left_step  = decode(prev_pins_reg.left_a, prev_pins_reg.left_b,
                            pins.left_a, pins.left_b);

        prev_pins_next  = prev_pins_reg;
        pins_known_next = pins_known_reg;
        right_acc_next  = right_acc_reg;
        left_acc_next   = left_acc_reg;
        invalid_next    = invalid_reg;

        latch_next              = latch_reg;
        latch_next.valid        = 1'b0;

        if (accept && cmd == CMD_SAMPLE)
        begin
            if (pins_known_reg)
            begin
                right_acc_next = step_acc(right_acc_reg, right_step);
                left_acc_next  = step_acc(left_acc_reg, left_step);
                invalid_next   = invalid_reg | right_step.invalid | left_step.invalid;
            end
            prev_pins_next  = pins;
            pins_known_next = 1'b1;
        end
        else if (accept && cmd == CMD_TICK)
        begin
            latch_next.valid        = 1'b1;
            latch_next.right_count  = sat_count(right_acc_reg);
            latch_next.left_count   = sat_count(left_acc_reg);
            latch_next.invalid_seen = invalid_reg;
            right_acc_next          = '0;
            left_acc_next           = '0;
            invalid_next            = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg   <= '0;
            pins_known_reg  <= 1'b0;
            right_acc_reg   <= '0;
            left_acc_reg    <= '0;
            invalid_reg     <= 1'b0;
            latch_reg       <= '0;
        end
        else
        begin
            prev_pins_reg  <= prev_pins_next;
            pins_known_reg <= pins_known_next;
            right_acc_reg  <= right_acc_next;
            left_acc_reg   <= left_acc_next;
            invalid_reg    <= invalid_next;
            if (advance)
                latch_reg <= latch_next;
        end
    end

    assign latch = latch_reg;

endmodule

### hdl/qvc_scaler.sv
// Scaling of the latched counts to velocities, mean of both and the result register.
module qvc_scaler
    import qvc_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic [SCALE_WIDTH-1:0]              distance_scale,
    input  qvc_latch_t                          latch,
    output logic                                out_valid,
    output logic signed [OUT_COUNT_WIDTH-1:0]   right_count,
    output logic signed [OUT_COUNT_WIDTH-1:0]   left_count,
    output logic signed [VEL_WIDTH-1:0]         right_velocity,
    output logic signed [VEL_WIDTH-1:0]         left_velocity,
    output logic signed [VEL_WIDTH-1:0]         mean_velocity,
    output logic                                invalid_seen
);

    localparam int ProdWidth = OUT_COUNT_WIDTH + SCALE_WIDTH + 1;

    logic                               mul_valid_reg;
    logic signed [OUT_COUNT_WIDTH-1:0]  mul_rc_reg;
    logic signed [OUT_COUNT_WIDTH-1:0]  mul_lc_reg;
    logic signed [VEL_WIDTH-1:0]        mul_rv_reg;
    logic signed [VEL_WIDTH-1:0]        mul_lv_reg;
    logic                               mul_inv_reg;

    logic                               out_valid_reg;
    logic signed [OUT_COUNT_WIDTH-1:0]  out_rc_reg;
    logic signed [OUT_COUNT_WIDTH-1:0]  out_lc_reg;
    logic signed [VEL_WIDTH-1:0]        out_rv_reg;
    logic signed [VEL_WIDTH-1:0]        out_lv_reg;
    logic signed [VEL_WIDTH-1:0]        out_mean_reg;
    logic                               out_inv_reg;

    logic signed [SCALE_WIDTH:0]        scale_s;
    logic signed [ProdWidth-1:0]        right_prod;
    logic signed [ProdWidth-1:0]        left_prod;
    logic signed [VEL_WIDTH:0]          vel_sum;
    logic signed [VEL_WIDTH-1:0]        mean_next;

    always_comb
    begin
        scale_s    = signed'({1'b0, distance_scale});
        right_prod = ProdWidth'(latch.right_count) * ProdWidth'(scale_s);
        left_prod  = ProdWidth'(latch.left_count) * ProdWidth'(scale_s);
        vel_sum    = (VEL_WIDTH+1)'(mul_rv_reg) + (VEL_WIDTH+1)'(mul_lv_reg);
        mean_next  = vel_sum[VEL_WIDTH:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            mul_valid_reg <= latch.valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            mul_rc_reg   <= latch.right_count;
            mul_lc_reg   <= latch.left_count;
            mul_rv_reg   <= right_prod[VEL_WIDTH-1:0];
            mul_lv_reg   <= left_prod[VEL_WIDTH-1:0];
            mul_inv_reg  <= latch.invalid_seen;
            out_rc_reg   <= mul_rc_reg;
            out_lc_reg   <= mul_lc_reg;
            out_rv_reg   <= mul_rv_reg;
            out_lv_reg   <= mul_lv_reg;
            out_mean_reg <= mean_next;
            out_inv_reg  <= mul_inv_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign right_count    = out_rc_reg;
    assign left_count     = out_lc_reg;
    assign right_velocity = out_rv_reg;
    assign left_velocity  = out_lv_reg;
    assign mean_velocity  = out_mean_reg;
    assign invalid_seen   = out_inv_reg;

endmodule

### hdl/dual_quadrature_velocity_counter.sv
// Top level of the dual quadrature velocity counter with its register port.
// Pin samples update the counts at the edge that accepts them and yield no result.
// A tick item's result becomes valid after the edge that accepts it,
// once it has passed the latch, multiply and mean stages.
// Throughput is one item per cycle; all stages and the input stall while a result waits.
// Reset clears counts, pin history and the invalid flag and sets the scale to 1.0.
module dual_quadrature_velocity_counter
    import qvc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Register port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_WIDTH-1:0]      paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input items.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: right_a, right_b, left_a, left_b, zero fill.
    input  logic [TDATA_IN_WIDTH-1:0]   s_axis_tdata,
    // Field: cmd.
    input  logic                        s_axis_tuser,
    // Result items.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0: right_count, left_count, right_velocity, left_velocity,
    // mean_velocity.
    output logic [TDATA_OUT_WIDTH-1:0]  m_axis_tdata,
    // Field: invalid_seen.
    output logic                        m_axis_tuser
);

    logic [SCALE_WIDTH-1:0]             scale_reg;
    logic                               advance;
    logic                               accept;
    logic                               reg_write;
    qvc_pins_t                          pins;
    qvc_latch_t                         latch;
    logic                               out_valid;
    logic signed [OUT_COUNT_WIDTH-1:0]  right_count;
    logic signed [OUT_COUNT_WIDTH-1:0]  left_count;
    logic signed [VEL_WIDTH-1:0]        right_velocity;
    logic signed [VEL_WIDTH-1:0]        left_velocity;
    logic signed [VEL_WIDTH-1:0]        mean_velocity;
    logic                               invalid_seen;

    assign pready    = 1'b1;
    assign reg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (reg_write && paddr[2] == REG_DISTANCE_SCALE)
            scale_reg <= pwdata[SCALE_WIDTH-1:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_DISTANCE_SCALE)
            prdata = 32'(scale_reg);
        else
            prdata = '0;
    end

    assign advance       = ~out_valid | m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid & advance;

    assign pins.right_a = s_axis_tdata[0];
    assign pins.right_b = s_axis_tdata[1];
    assign pins.left_a  = s_axis_tdata[2];
    assign pins.left_b  = s_axis_tdata[3];

    qvc_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .advance (advance),
        .cmd     (s_axis_tuser),
        .pins    (pins),
        .latch   (latch)
    );

    qvc_scaler u_scaler (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .distance_scale (scale_reg),
        .latch          (latch),
        .out_valid      (out_valid),
        .right_count    (right_count),
        .left_count     (left_count),
        .right_velocity (right_velocity),
        .left_velocity  (left_velocity),
        .mean_velocity  (mean_velocity),
        .invalid_seen   (invalid_seen)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {mean_velocity, left_velocity, right_velocity,
                            left_count, right_count};
    assign m_axis_tuser  = invalid_seen;

endmodule

### sim/qvc_result_check.sv
// Predictor and result comparison for the dual quadrature velocity counter test.
`timescale 1ns / 100ps
module qvc_result_check
    import qvc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_WIDTH-1:0]      paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    // Fields from bit 0: right_a, right_b, left_a, left_b, zero fill.
    input  logic [TDATA_IN_WIDTH-1:0]   s_axis_tdata,
    // Field: cmd.
    input  logic                        s_axis_tuser,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0: right_count, left_count, right_velocity, left_velocity,
    // mean_velocity.
    input  logic [TDATA_OUT_WIDTH-1:0]  m_axis_tdata,
    // Field: invalid_seen.
    input  logic                        m_axis_tuser,
    output int                          mismatches,
    output int                          outstanding,
    output int                          results_checked
);

    localparam logic [PADDR_WIDTH-1:0] ADDR_DISTANCE_SCALE =
        PADDR_WIDTH'({REG_DISTANCE_SCALE, 2'b00});
    localparam int LEFT_COUNT_LSB = OUT_COUNT_WIDTH;
    localparam int RIGHT_VEL_LSB  = 2 * OUT_COUNT_WIDTH;
    localparam int LEFT_VEL_LSB   = RIGHT_VEL_LSB + VEL_WIDTH;
    localparam int MEAN_VEL_LSB   = LEFT_VEL_LSB + VEL_WIDTH;

    typedef struct {
        logic signed [OUT_COUNT_WIDTH-1:0] right_count;
        logic signed [OUT_COUNT_WIDTH-1:0] left_count;
        logic signed [VEL_WIDTH-1:0]       right_velocity;
        logic signed [VEL_WIDTH-1:0]       left_velocity;
        logic signed [VEL_WIDTH-1:0]       mean_velocity;
        logic                              invalid_seen;
    } tick_result_t;

    logic [SCALE_WIDTH-1:0]        scale;
    qvc_pins_t                     last_pins;
    logic                          pins_loaded;
    logic signed [COUNT_WIDTH-1:0] right_acc;
    logic signed [COUNT_WIDTH-1:0] left_acc;
    logic                          double_change;
    tick_result_t                  tick_results[$];

    function automatic longint clamp(input longint v, input longint hi);
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Pairs are {b, a}. Returns the count step and flags a change of both pins.
    function automatic int quad_step(input logic [1:0] was_ba, input logic [1:0] now_ba,
                                     output logic both);
        logic a_moved;
        logic b_moved;
        a_moved = (was_ba[0] != now_ba[0]);
        b_moved = (was_ba[1] != now_ba[1]);
        both = a_moved && b_moved;
        if (both)
            return 0;
        if (a_moved)
            return (now_ba[0] == now_ba[1]) ? 1 : -1;
        if (b_moved)
            return (now_ba[0] != now_ba[1]) ? 1 : -1;
        return 0;
    endfunction

    task automatic flag(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got)
            flag($sformatf("tick result %0d, %s: expected %0d, actual %0d",
                           results_checked, field, want, got));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        qvc_pins_t    pins;
        int           dr;
        int           dl;
        logic         both_r;
        logic         both_l;
        longint       acc_hi;
        longint       count_hi;
        longint       rc;
        longint       lc;
        longint       rv;
        longint       lv;
        longint       scale64;
        tick_result_t want;
        tick_result_t got;
        if (!rst_n)
        begin
            scale = SCALE_RESET;
            last_pins = '0;
            pins_loaded = 1'b0;
            right_acc = '0;
            left_acc = '0;
            double_change = 1'b0;
            tick_results.delete();
            mismatches = 0;
            results_checked = 0;
            outstanding <= 0;
        end
        else
        begin
            acc_hi = (longint'(1) <<< (COUNT_WIDTH - 1)) - 1;
            count_hi = (longint'(1) <<< (OUT_COUNT_WIDTH - 1)) - 1;

            if (psel && penable && pready && paddr == ADDR_DISTANCE_SCALE)
            begin
                if (pwrite)
                    scale = pwdata[SCALE_WIDTH-1:0];
                else if (prdata !== 32'(scale))
                    flag($sformatf("distance_scale read: expected %0d, actual %0d",
                                   scale, prdata));
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                pins = qvc_pins_t'(s_axis_tdata[3:0]);
                if (s_axis_tuser == CMD_SAMPLE)
                begin
                    if (pins_loaded)
                    begin
                        dr = quad_step({last_pins.right_b, last_pins.right_a},
                                       {pins.right_b, pins.right_a}, both_r);
                        dl = quad_step({last_pins.left_b, last_pins.left_a},
                                       {pins.left_b, pins.left_a}, both_l);
                        if (both_r || both_l)
                            double_change = 1'b1;
                        right_acc = COUNT_WIDTH'(clamp(longint'(right_acc) + dr, acc_hi));
                        left_acc = COUNT_WIDTH'(clamp(longint'(left_acc) + dl, acc_hi));
                    end
                    last_pins = pins;
                    pins_loaded = 1'b1;
                end
                else
                begin
                    rc = clamp(right_acc, count_hi);
                    lc = clamp(left_acc, count_hi);
                    scale64 = scale;
                    rv = rc * scale64;
                    lv = lc * scale64;
                    want.right_count = OUT_COUNT_WIDTH'(rc);
                    want.left_count = OUT_COUNT_WIDTH'(lc);
                    want.right_velocity = VEL_WIDTH'(rv);
                    want.left_velocity = VEL_WIDTH'(lv);
                    want.mean_velocity = VEL_WIDTH'((rv + lv) >>> 1);
                    want.invalid_seen = double_change;
                    tick_results.push_back(want);
                    right_acc = '0;
                    left_acc = '0;
                    double_change = 1'b0;
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tick_results.size() == 0)
                    flag("result item with no tick pending");
                else
                begin
                    want = tick_results.pop_front();
                    results_checked++;
                    if ($isunknown({m_axis_tuser, m_axis_tdata}))
                        flag($sformatf("tick result %0d has unknown bits", results_checked));
                    else
                    begin
                        got.right_count = m_axis_tdata[LEFT_COUNT_LSB-1:0];
                        got.left_count = m_axis_tdata[RIGHT_VEL_LSB-1:LEFT_COUNT_LSB];
                        got.right_velocity = m_axis_tdata[LEFT_VEL_LSB-1:RIGHT_VEL_LSB];
                        got.left_velocity = m_axis_tdata[MEAN_VEL_LSB-1:LEFT_VEL_LSB];
                        got.mean_velocity = m_axis_tdata[MEAN_VEL_LSB+VEL_WIDTH-1:MEAN_VEL_LSB];
                        got.invalid_seen = m_axis_tuser;
                        compare_field("right_count", want.right_count, got.right_count);
                        compare_field("left_count", want.left_count, got.left_count);
                        compare_field("right_velocity", want.right_velocity,
                                      got.right_velocity);
                        compare_field("left_velocity", want.left_velocity, got.left_velocity);
                        compare_field("mean_velocity", want.mean_velocity, got.mean_velocity);
                        compare_field("invalid_seen", want.invalid_seen, got.invalid_seen);
                    end
                end
            end

            outstanding <= tick_results.size();
        end
    end

endmodule

### sim/tb_top.sv
// Clock, reset, stimulus and verdict for the dual quadrature velocity counter test.
`timescale 1ns / 100ps
module tb_top;
    import qvc_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam logic [PADDR_WIDTH-1:0] ADDR_DISTANCE_SCALE =
        PADDR_WIDTH'({REG_DISTANCE_SCALE, 2'b00});
    // Forward quadrature cycle of {b, a} pairs, phase 0 in the lowest bits.
    localparam logic [7:0] QUAD_CYCLE = 8'b01_11_10_00;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_WIDTH-1:0]     paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [TDATA_IN_WIDTH-1:0]  s_axis_tdata;
    logic                       s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [TDATA_OUT_WIDTH-1:0] m_axis_tdata;
    logic                       m_axis_tuser;

    int         mismatches;
    int         outstanding;
    int         results_checked;
    int         sender_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         items_sent = 0;
    int         scale_writes = 0;
    int         quiet_cycles = 0;
    logic [3:0] cur_pins = 4'b0000;

    dual_quadrature_velocity_counter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    qvc_result_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [1:0] advance(input logic [1:0] ba, input int d);
        int ph;
        ph = 0;
        for (int i = 0; i < 4; i++)
            if (QUAD_CYCLE[2*i +: 2] == ba)
                ph = i;
        return QUAD_CYCLE[2*((ph + d + 4) % 4) +: 2];
    endfunction

    // A move of two phases changes both pins of the encoder at once.
    function automatic int random_move();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 1;
        if (r < 75)
            return -1;
        if (r < 92)
            return 0;
        return 2;
    endfunction

    task automatic send_item(input logic cmd, input logic [3:0] pins);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= TDATA_IN_WIDTH'(pins);
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_sample(input logic [3:0] pins);
        cur_pins = pins;
        send_item(CMD_SAMPLE, pins);
    endtask

    task automatic step_pins(input int dr, input int dl);
        send_sample({advance(cur_pins[3:2], dl), advance(cur_pins[1:0], dr)});
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= ADDR_DISTANCE_SCALE;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The upper data bits are random; only the low 24 bits reach the register.
    task automatic set_scale(input logic [SCALE_WIDTH-1:0] value);
        wait_idle();
        apb_access(1'b1, {8'($urandom), value});
        apb_access(1'b0, 32'd0);
        scale_writes++;
    endtask

    // Mostly legal quadrature steps, with some noise samples and ticks.
    task automatic run_random(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_item(CMD_TICK, 4'($urandom));
            else if (pick < 20)
                send_sample(4'($urandom));
            else
                step_pins(random_move(), random_move());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_SAMPLE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, 32'd0);

        // A tick before any sample, then a first sample that only loads the pins.
        send_item(CMD_TICK, 4'b0000);
        send_sample(4'b1111);
        send_item(CMD_TICK, 4'b0000);
        step_pins(1, -1);
        step_pins(1, -1);
        step_pins(-1, 1);
        step_pins(0, 0);
        step_pins(-1, 1);
        step_pins(2, 0);
        send_item(CMD_TICK, 4'b1010);
        step_pins(0, 2);
        step_pins(1, 1);
        send_item(CMD_TICK, 4'b0101);
        step_pins(2, 2);
        send_sample(cur_pins ^ 4'b0101);
        send_sample(4'b0000);
        send_item(CMD_TICK, 4'b1111);
        send_item(CMD_TICK, 4'b0000);

        set_scale(SCALE_WIDTH'($urandom_range(24'hFFFFFF)));
        run_random(225);
        sender_idle_pct = 71;
        set_scale(24'd0);
        run_random(225);
        sender_idle_pct = 0;
        recv_stall_pct = 71;
        set_scale(24'hFFFFFF);
        run_random(225);
        sender_idle_pct = 11;
        recv_stall_pct = 11;
        set_scale(24'd1);
        run_random(225);
        wait_idle();

        $display("Sent %0d items under four idle patterns and checked %0d tick results.",
                 items_sent, results_checked);
        $display("Wrote %0d scale settings, including zero and full scale.",
                 scale_writes);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
hdl/qvc_pkg.sv
hdl/qvc_decoder.sv
hdl/qvc_scaler.sv
hdl/dual_quadrature_velocity_counter.sv
sim/qvc_result_check.sv
sim/tb_top.sv
